[src/wheel_odometry_pose_update_defines.svh]
// Assertion macros for the wheel odometry pose block.
// Included by files that check their own control logic; needs clk_i and rst_ni in scope.
`ifndef WHEEL_ODOMETRY_POSE_UPDATE_DEFINES_SVH
`define WHEEL_ODOMETRY_POSE_UPDATE_DEFINES_SVH

// Check a property on every clock edge outside reset
`define WOP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a trigger implies a consequence on the next edge
`define WOP_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/wop_pkg.sv]
// Shared types, constants and tables for the wheel odometry pose block.
// Used by wop_mul, wheel_odometry_pose_update and the testbench; depends on nothing.
package wop_pkg;

  // Fixed-point format of angles and lengths
  localparam int FRAC_BITS = 16;
  localparam int TRIG_FRAC = 30;
  localparam int Z_SHIFT   = TRIG_FRAC - FRAC_BITS;

  // Field widths
  localparam int ANGLE_W   = 32;
  localparam int HEAD_W    = 19;
  localparam int RADIUS_W  = 16;
  localparam int PERIOD_W  = 3;
  localparam int FACTOR_W  = 16;

  // 2*pi, rounded to the heading format
  localparam longint TWO_PI_Q32 = 64'd26986075409;
  localparam longint TWO_PI_L   =
    (TWO_PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam logic [HEAD_W:0] TWO_PI = (HEAD_W + 1)'(TWO_PI_L);

  // Rotation unit constants, Q2.30
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = 5;
  localparam int Z_W          = 36;
  localparam int XY_W         = 34;
  localparam logic signed [Z_W-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 34'sd652032874;

  // Shared multiplier widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 66;

  // Register map, word index of paddr
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_TURN_ANGLE   = 2'd0;
  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd1;
  localparam logic [1:0] REG_CORR_PERIOD  = 2'd2;
  localparam logic [1:0] REG_CORR_FACTOR  = 2'd3;

  // Register reset values
  localparam logic [HEAD_W-1:0]   TURN_ANGLE_RST   = 19'd185299;
  localparam logic [RADIUS_W-1:0] WHEEL_RADIUS_RST = 16'd2032;
  localparam logic [PERIOD_W-1:0] CORR_PERIOD_RST  = 3'd5;
  localparam logic [FACTOR_W-1:0] CORR_FACTOR_RST  = 16'd63015;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ML,
    S_MR,
    S_HD,
    S_HS,
    S_WRAP,
    S_TOT,
    S_ROT,
    S_XL,
    S_XH,
    S_XA,
    S_XW,
    S_YH,
    S_YA,
    S_YW,
    S_PUB
  } state_e;

  // Arctangent of 2^-i, Q2.30
  function automatic logic [TRIG_FRAC-1:0] atan_q30(input logic [ITER_W-1:0] i);
    logic [TRIG_FRAC-1:0] r;
    case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/wop_mul.sv]
// Registered signed multiplier shared by every product of the pose update.
// Depends on wop_pkg for operand widths.
module wop_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [wop_pkg::MUL_A_W-1:0]   a_i,
  input  logic signed [wop_pkg::MUL_B_W-1:0]   b_i,
  output logic signed [wop_pkg::MUL_P_W-1:0]   p_o
);

  logic signed [wop_pkg::MUL_P_W-1:0] p_q;

  // Multiply and hold the product for the next step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= wop_pkg::MUL_P_W'(a_i) * wop_pkg::MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

[src/wheel_odometry_pose_update.sv]
// Differential-drive pose update: one request in, one pose out. A new request is taken only
// once the previous pose has gone to the result slot; the 30-step rotation loop on the
// shift-add unit takes most of the sequence, with one shared multiplier for the rest.
// rst_ni clears pose, wheel history and turn counter and loads the register defaults.
// Depends on wop_pkg, wop_mul and wheel_odometry_pose_update_defines.svh.
`include "wheel_odometry_pose_update_defines.svh"

module wheel_odometry_pose_update (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [wop_pkg::ANGLE_W-1:0]     left_wheel_angle_i,
  input  logic signed [wop_pkg::ANGLE_W-1:0]     right_wheel_angle_i,
  input  logic                                   turned_i,
  // Pose channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [wop_pkg::ANGLE_W-1:0]     x_position_o,
  output logic signed [wop_pkg::ANGLE_W-1:0]     y_position_o,
  output logic        [wop_pkg::HEAD_W-1:0]      heading_o,
  output logic        [wop_pkg::ANGLE_W-1:0]     distance_travelled_o,
  // Register port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [wop_pkg::ADDR_W-1:0]      paddr,
  input  logic        [31:0]                     pwdata,
  output logic        [31:0]                     prdata,
  output logic                                   pready
);

  localparam int AW = wop_pkg::ANGLE_W;
  localparam int HW = wop_pkg::HEAD_W;

  // Registers
  logic [HW-1:0]                    turn_angle_q;
  logic [wop_pkg::RADIUS_W-1:0]     wheel_radius_q;
  logic [wop_pkg::PERIOD_W-1:0]     corr_period_q;
  logic [wop_pkg::FACTOR_W-1:0]     corr_factor_q;
  logic                             cfg_wr;

  // Sequencer and datapath state
  wop_pkg::state_e                  state_q, state_d;
  logic signed [AW-1:0]             left_q, right_q;
  logic                             turned_q;
  logic [HW-1:0]                    heading_q, heading_d;
  logic signed [AW-1:0]             x_q, x_d, y_q, y_d;
  logic [AW-1:0]                    total_q, total_d;
  logic signed [AW-1:0]             prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic [wop_pkg::PERIOD_W-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]                    magl_q, magl_d;
  logic [AW-1:0]                    step_q, step_d;
  logic [HW:0]                      hwrap_q, hwrap_d;
  logic signed [wop_pkg::Z_W-1:0]   z_q, z_d;
  logic signed [wop_pkg::XY_W-1:0]  xc_q, xc_d, yc_q, yc_d;
  logic                             neg_q, neg_d;
  logic [wop_pkg::ITER_W-1:0]       iter_q, iter_d;
  logic signed [wop_pkg::ACC_W-1:0] acc_q, acc_d;

  // Result slot
  logic                             out_valid_q, out_valid_d;
  logic signed [AW-1:0]             out_x_q, out_y_q;
  logic [HW-1:0]                    out_head_q;
  logic [AW-1:0]                    out_tot_q;
  logic                             pub;

  // Shared multiplier
  logic                                  mul_en;
  logic signed [wop_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [wop_pkg::MUL_B_W-1:0]    mul_b;
  logic signed [wop_pkg::MUL_P_W-1:0]    prod;

  // Combinational helpers
  logic signed [AW-1:0]             dist_w, prev_sel;
  logic signed [AW:0]               diff_w;
  logic [AW:0]                      mag_w;
  logic [AW:0]                      step_sum;
  logic [AW:0]                      tot_sum;
  logic signed [wop_pkg::Z_W-1:0]   z0, z1, z2, at_w;
  logic                             n1, n2;
  logic signed [wop_pkg::XY_W-1:0]  dx, dy, cos_w, sin_w;
  logic [HW-1:0]                    h_scaled;
  logic                             accept;

  assign accept     = in_valid_i && (state_q == wop_pkg::S_IDLE);
  assign in_stall_o = (state_q != wop_pkg::S_IDLE);

  wop_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Register port: write on the access phase, read any time
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_angle_q   <= wop_pkg::TURN_ANGLE_RST;
      wheel_radius_q <= wop_pkg::WHEEL_RADIUS_RST;
      corr_period_q  <= wop_pkg::CORR_PERIOD_RST;
      corr_factor_q  <= wop_pkg::CORR_FACTOR_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wop_pkg::REG_TURN_ANGLE:   turn_angle_q   <= pwdata[HW-1:0];
        wop_pkg::REG_WHEEL_RADIUS: wheel_radius_q <= pwdata[wop_pkg::RADIUS_W-1:0];
        wop_pkg::REG_CORR_PERIOD:  corr_period_q  <= pwdata[wop_pkg::PERIOD_W-1:0];
        wop_pkg::REG_CORR_FACTOR:  corr_factor_q  <= pwdata[wop_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wop_pkg::REG_TURN_ANGLE:   prdata = 32'(turn_angle_q);
      wop_pkg::REG_WHEEL_RADIUS: prdata = 32'(wheel_radius_q);
      wop_pkg::REG_CORR_PERIOD:  prdata = 32'(corr_period_q);
      wop_pkg::REG_CORR_FACTOR:  prdata = 32'(corr_factor_q);
      default:                   prdata = '0;
    endcase
  end

  // Wheel distance from the product, change against the stored distance, magnitude
  assign dist_w   = prod[AW+15:16];
  assign prev_sel = (state_q == wop_pkg::S_MR) ? prev_l_q : prev_r_q;
  assign diff_w   = (AW + 1)'(dist_w) - (AW + 1)'(prev_sel);
  assign mag_w    = diff_w[AW] ? (AW + 1)'(-diff_w) : diff_w;
  assign step_sum = {1'b0, magl_q} + {1'b0, mag_w[AW-1:0]};
  assign tot_sum  = {1'b0, total_q} + {1'b0, step_q};
  assign h_scaled = prod[HW+15:16];

  // Fold the heading into [-pi/2, pi/2] and remember the sign flip
  assign z0 = wop_pkg::Z_W'(heading_q) <<< wop_pkg::Z_SHIFT;
  assign n1 = (z0 >= wop_pkg::PI_Q30);
  assign z1 = n1 ? z0 - wop_pkg::PI_Q30 : z0;
  assign n2 = (z1 > wop_pkg::HALF_PI_Q30);
  assign z2 = n2 ? z1 - wop_pkg::PI_Q30 : z1;

  // Shift-add step of the rotation
  assign dx    = yc_q >>> iter_q;
  assign dy    = xc_q >>> iter_q;
  assign at_w  = wop_pkg::Z_W'(wop_pkg::atan_q30(iter_q));
  assign cos_w = neg_q ? -xc_q : xc_q;
  assign sin_w = neg_q ? -yc_q : yc_q;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    heading_d   = heading_q;
    x_d         = x_q;
    y_d         = y_q;
    total_d     = total_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    cnt_d       = cnt_q;
    magl_d      = magl_q;
    step_d      = step_q;
    hwrap_d     = hwrap_q;
    z_d         = z_q;
    xc_d        = xc_q;
    yc_d        = yc_q;
    neg_d       = neg_q;
    iter_d      = iter_q;
    acc_d       = acc_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    pub         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      wop_pkg::S_IDLE: begin
        if (accept) begin
          state_d = wop_pkg::S_ML;
        end
      end
      // Left wheel angle times radius
      wop_pkg::S_ML: begin
        mul_en  = 1'b1;
        mul_a   = wop_pkg::MUL_A_W'(left_q);
        mul_b   = wop_pkg::MUL_B_W'(wheel_radius_q);
        state_d = wop_pkg::S_MR;
      end
      // Right wheel product; take the left change
      wop_pkg::S_MR: begin
        mul_en   = 1'b1;
        mul_a    = wop_pkg::MUL_A_W'(right_q);
        mul_b    = wop_pkg::MUL_B_W'(wheel_radius_q);
        magl_d   = mag_w[AW-1:0];
        prev_l_d = dist_w;
        state_d  = wop_pkg::S_HD;
      end
      // Form the step; on a turn, advance the turn counter or, at the period, start the correction
      wop_pkg::S_HD: begin
        step_d   = step_sum[AW:1];
        prev_r_d = dist_w;
        if (turned_q) begin
          if (cnt_q + 3'd1 == corr_period_q) begin
            cnt_d   = '0;
            mul_en  = 1'b1;
            mul_a   = wop_pkg::MUL_A_W'(heading_q);
            mul_b   = wop_pkg::MUL_B_W'(corr_factor_q);
            state_d = wop_pkg::S_HS;
          end else begin
            cnt_d   = cnt_q + 3'd1;
            hwrap_d = {1'b0, heading_q} + {1'b0, turn_angle_q};
            state_d = wop_pkg::S_WRAP;
          end
        end else begin
          state_d = wop_pkg::S_TOT;
        end
      end
      // Scaled heading plus the turn
      wop_pkg::S_HS: begin
        hwrap_d = {1'b0, h_scaled} + {1'b0, turn_angle_q};
        state_d = wop_pkg::S_WRAP;
      end
      // Reduce modulo 2*pi, one subtraction a cycle
      wop_pkg::S_WRAP: begin
        if (hwrap_q >= wop_pkg::TWO_PI) begin
          hwrap_d = hwrap_q - wop_pkg::TWO_PI;
        end else begin
          heading_d = hwrap_q[HW-1:0];
          state_d   = wop_pkg::S_TOT;
        end
      end
      // Saturate the path length; load the rotation
      wop_pkg::S_TOT: begin
        total_d = tot_sum[AW] ? '1 : tot_sum[AW-1:0];
        z_d     = z2;
        neg_d   = n1 ^ n2;
        xc_d    = wop_pkg::GAIN_Q30;
        yc_d    = '0;
        iter_d  = '0;
        state_d = wop_pkg::S_ROT;
      end
      wop_pkg::S_ROT: begin
        if (z_q >= 0) begin
          xc_d = xc_q - dx;
          yc_d = yc_q + dy;
          z_d  = z_q - at_w;
        end else begin
          xc_d = xc_q + dx;
          yc_d = yc_q - dy;
          z_d  = z_q + at_w;
        end
        iter_d = iter_q + 5'd1;
        if (iter_q == wop_pkg::ITER_W'(wop_pkg::CORDIC_ITERS - 1)) begin
          state_d = wop_pkg::S_XL;
        end
      end
      // Step times cosine, low then high half of the step
      wop_pkg::S_XL: begin
        mul_en  = 1'b1;
        mul_a   = cos_w[wop_pkg::MUL_A_W-1:0];
        mul_b   = wop_pkg::MUL_B_W'(step_q[15:0]);
        state_d = wop_pkg::S_XH;
      end
      wop_pkg::S_XH: begin
        mul_en  = 1'b1;
        mul_a   = cos_w[wop_pkg::MUL_A_W-1:0];
        mul_b   = wop_pkg::MUL_B_W'(step_q[AW-1:16]);
        acc_d   = wop_pkg::ACC_W'(prod);
        state_d = wop_pkg::S_XA;
      end
      wop_pkg::S_XA: begin
        acc_d   = acc_q + (wop_pkg::ACC_W'(prod) <<< 16);
        state_d = wop_pkg::S_XW;
      end
      // Add to x; start the sine products
      wop_pkg::S_XW: begin
        x_d     = x_q + acc_q[AW+29:30];
        mul_en  = 1'b1;
        mul_a   = sin_w[wop_pkg::MUL_A_W-1:0];
        mul_b   = wop_pkg::MUL_B_W'(step_q[15:0]);
        state_d = wop_pkg::S_YH;
      end
      wop_pkg::S_YH: begin
        mul_en  = 1'b1;
        mul_a   = sin_w[wop_pkg::MUL_A_W-1:0];
        mul_b   = wop_pkg::MUL_B_W'(step_q[AW-1:16]);
        acc_d   = wop_pkg::ACC_W'(prod);
        state_d = wop_pkg::S_YA;
      end
      wop_pkg::S_YA: begin
        acc_d   = acc_q + (wop_pkg::ACC_W'(prod) <<< 16);
        state_d = wop_pkg::S_YW;
      end
      wop_pkg::S_YW: begin
        y_d     = y_q + acc_q[AW+29:30];
        state_d = wop_pkg::S_PUB;
      end
      // Hand the pose to the result slot once it is free
      wop_pkg::S_PUB: begin
        if (!out_valid_q || !out_stall_i) begin
          pub         = 1'b1;
          out_valid_d = 1'b1;
          state_d     = wop_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wop_pkg::S_IDLE;
      end
    endcase
  end

  // Control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wop_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
      x_q         <= '0;
      y_q         <= '0;
      total_q     <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      cnt_q       <= '0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      heading_q   <= heading_d;
      x_q         <= x_d;
      y_q         <= y_d;
      total_q     <= total_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      cnt_q       <= cnt_d;
      iter_q      <= iter_d;
    end
  end

  // Working registers and request capture
  always_ff @(posedge clk_i) begin
    magl_q  <= magl_d;
    step_q  <= step_d;
    hwrap_q <= hwrap_d;
    z_q     <= z_d;
    xc_q    <= xc_d;
    yc_q    <= yc_d;
    neg_q   <= neg_d;
    acc_q   <= acc_d;
    if (accept) begin
      left_q   <= left_wheel_angle_i;
      right_q  <= right_wheel_angle_i;
      turned_q <= turned_i;
    end
    if (pub) begin
      out_x_q    <= x_q;
      out_y_q    <= y_q;
      out_head_q <= heading_q;
      out_tot_q  <= total_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign x_position_o         = out_x_q;
  assign y_position_o         = out_y_q;
  assign heading_o            = out_head_q;
  assign distance_travelled_o = out_tot_q;

  // Heading never leaves [0, 2*pi)
  `WOP_ASSERT(a_heading_range, {1'b0, heading_q} < wop_pkg::TWO_PI, "heading out of range")
  // Rotation counter stays inside the loop
  `WOP_ASSERT(a_iter_bound, (state_q != wop_pkg::S_ROT) || (iter_q < wop_pkg::ITER_W'(wop_pkg::CORDIC_ITERS)), "rotation overran")
  // An accepted request starts the sequence
  `WOP_ASSERT_NEXT(a_start, in_valid_i && !in_stall_o, state_q == wop_pkg::S_ML, "request not started")
  // A publish step fills the result slot and returns the sequencer to idle
  `WOP_ASSERT_NEXT(a_pub_slot, pub, out_valid_o && (state_q == wop_pkg::S_IDLE), "publish lost")

endmodule

[tb/sv/pose_check_pkg.sv]
`timescale 1ns / 100ps
// Pose predictor and scoreboard for the wheel odometry pose update testbench.
// Depends on wop_pkg for field widths, register indexes and register defaults.
package pose_check_pkg;

  // One pose as the block reports it
  typedef struct packed {
    logic signed [wop_pkg::ANGLE_W-1:0] x_pos;
    logic signed [wop_pkg::ANGLE_W-1:0] y_pos;
    logic        [wop_pkg::HEAD_W-1:0]  heading;
    logic        [wop_pkg::ANGLE_W-1:0] distance;
  } pose_t;

  // 2*pi rounded to Q16.16; the heading lives in [0, HEADING_WRAP)
  localparam longint HEADING_WRAP = (64'd26986075409 + 64'd32768) >> 16;
  localparam longint DIST_MAX     = 64'd4294967295;

  // Shift-add rotation constants, Q2.30
  localparam int     ROT_STEPS   = 30;
  localparam longint ROT_PI      = 64'sd3373259426;
  localparam longint ROT_HALF_PI = 64'sd1686629713;
  localparam longint ROT_GAIN    = 64'sd652032874;
  localparam longint ROT_ANGLE [ROT_STEPS] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  class pose_tracker;
    // Register copies
    logic [wop_pkg::HEAD_W-1:0]   turn_angle;
    logic [wop_pkg::RADIUS_W-1:0] wheel_radius;
    logic [wop_pkg::PERIOD_W-1:0] corr_period;
    logic [wop_pkg::FACTOR_W-1:0] corr_factor;

    // Pose and wheel history
    logic [wop_pkg::HEAD_W-1:0]   heading;
    logic signed [31:0]           x_pos;
    logic signed [31:0]           y_pos;
    logic [31:0]                  distance;
    logic signed [31:0]           last_left;
    logic signed [31:0]           last_right;
    logic [wop_pkg::PERIOD_W-1:0] turn_count;

    pose_t pending_poses[$];
    int    requests;
    int    poses;
    int    turns;
    int    corrections;
    int    mismatches;
    bit    saturated;

    function new();
      turn_angle   = wop_pkg::TURN_ANGLE_RST;
      wheel_radius = wop_pkg::WHEEL_RADIUS_RST;
      corr_period  = wop_pkg::CORR_PERIOD_RST;
      corr_factor  = wop_pkg::CORR_FACTOR_RST;
      heading      = '0;
      x_pos        = '0;
      y_pos        = '0;
      distance     = '0;
      last_left    = '0;
      last_right   = '0;
      turn_count   = '0;
      requests     = 0;
      poses        = 0;
      turns        = 0;
      corrections  = 0;
      mismatches   = 0;
      saturated    = 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        wop_pkg::REG_TURN_ANGLE:   turn_angle   = value[wop_pkg::HEAD_W-1:0];
        wop_pkg::REG_WHEEL_RADIUS: wheel_radius = value[wop_pkg::RADIUS_W-1:0];
        wop_pkg::REG_CORR_PERIOD:  corr_period  = value[wop_pkg::PERIOD_W-1:0];
        default:                   corr_factor  = value[wop_pkg::FACTOR_W-1:0];
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        wop_pkg::REG_TURN_ANGLE:   return 32'(turn_angle);
        wop_pkg::REG_WHEEL_RADIUS: return 32'(wheel_radius);
        wop_pkg::REG_CORR_PERIOD:  return 32'(corr_period);
        default:                   return 32'(corr_factor);
      endcase
    endfunction

    function int pending();
      return pending_poses.size();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected 0x%08h, got 0x%08h", $time, what, want, got);
    endfunction

    // Cosine and sine of a heading, Q2.30, by 30 shift-add rotations
    function void rotate(logic [wop_pkg::HEAD_W-1:0] h, output longint cos_v,
                         output longint sin_v);
      longint z;
      longint xc;
      longint yc;
      longint nx;
      longint dx;
      longint dy;
      bit     flip;
      z    = longint'(h) << 14;
      xc   = ROT_GAIN;
      yc   = 0;
      flip = 1'b0;
      // fold into [-pi/2, pi/2], remember the sign
      if (z >= ROT_PI) begin
        z    = z - ROT_PI;
        flip = 1'b1;
      end
      if (z > ROT_HALF_PI) begin
        z    = z - ROT_PI;
        flip = !flip;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        dx = yc >>> i;
        dy = xc >>> i;
        if (z >= 0) begin
          nx = xc - dx;
          yc = yc + dy;
          z  = z - ROT_ANGLE[i];
        end else begin
          nx = xc + dx;
          yc = yc - dy;
          z  = z + ROT_ANGLE[i];
        end
        xc = nx;
      end
      cos_v = flip ? -xc : xc;
      sin_v = flip ? -yc : yc;
    endfunction

    // Advance the pose for one accepted request and queue the expected pose
    function void take_request(logic signed [31:0] left, logic signed [31:0] right,
                               logic turn);
      longint dl;
      longint dr;
      longint ml;
      longint mr;
      longint stp;
      longint tot;
      longint hd;
      longint cos_v;
      longint sin_v;
      longint dx;
      longint dy;
      pose_t  want;
      requests++;
      dl = (longint'(left) * longint'(wheel_radius)) >>> 16;
      dr = (longint'(right) * longint'(wheel_radius)) >>> 16;
      ml = dl - longint'(last_left);
      mr = dr - longint'(last_right);

      // turn: count, correct on the period, add the turn angle, wrap
      if (turn) begin
        turns++;
        turn_count = turn_count + 3'd1;
        if (turn_count == corr_period) begin
          hd         = (longint'(heading) * longint'(corr_factor)) >> 16;
          heading    = hd[wop_pkg::HEAD_W-1:0];
          turn_count = '0;
          corrections++;
        end
        hd      = (longint'(heading) + longint'(turn_angle)) % HEADING_WRAP;
        heading = hd[wop_pkg::HEAD_W-1:0];
      end

      // step is the mean absolute wheel travel
      if (ml < 0) ml = -ml;
      if (mr < 0) mr = -mr;
      stp = (ml + mr) >>> 1;

      // saturate the total path length
      tot = longint'(distance) + stp;
      if (tot > DIST_MAX) begin
        distance  = '1;
        saturated = 1'b1;
      end else begin
        distance = tot[31:0];
      end

      // project the step onto x and y, wrapping
      rotate(heading, cos_v, sin_v);
      dx    = (stp * cos_v) >>> 30;
      dy    = (stp * sin_v) >>> 30;
      x_pos = x_pos + dx[31:0];
      y_pos = y_pos + dy[31:0];

      last_left  = dl[31:0];
      last_right = dr[31:0];

      want.x_pos    = x_pos;
      want.y_pos    = y_pos;
      want.heading  = heading;
      want.distance = distance;
      pending_poses.push_back(want);
    endfunction

    // Compare one accepted pose with the oldest expectation
    function void check_pose(pose_t got);
      pose_t want;
      poses++;
      if (pending_poses.size() == 0) begin
        flag("pose with no request pending, x_position", 32'h0, got.x_pos);
        return;
      end
      want = pending_poses.pop_front();
      if (got.x_pos !== want.x_pos) flag("x_position", want.x_pos, got.x_pos);
      if (got.y_pos !== want.y_pos) flag("y_position", want.y_pos, got.y_pos);
      if (got.heading !== want.heading)
        flag("heading", 32'(want.heading), 32'(got.heading));
      if (got.distance !== want.distance)
        flag("distance_travelled", want.distance, got.distance);
    endfunction
  endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top-level testbench for wheel_odometry_pose_update: drives requests, register writes and
// output stalls, and scores each pose with pose_tracker from pose_check_pkg.
module testbench;
  import pose_check_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int LONG_HOLD    = 800;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 210;
  localparam int WALK_SPAN    = 1 << 24;
  localparam int WALK_STEP    = 1 << 20;
  localparam logic signed [31:0] ANG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ANG_MIN = 32'sh8000_0000;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_COMB} stall_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic signed [31:0] left_wheel_angle_i;
  logic signed [31:0] right_wheel_angle_i;
  logic        turned_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic signed [31:0] x_position_o;
  logic signed [31:0] y_position_o;
  logic [wop_pkg::HEAD_W-1:0] heading_o;
  logic [31:0] distance_travelled_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [wop_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pose_tracker        tracker;
  pose_t              seen_pose;
  int                 cycle_count;
  int                 long_holds;
  int                 settings;
  bit                 hold_wanted;
  logic signed [31:0] walk_left;
  logic signed [31:0] walk_right;

  wheel_odometry_pose_update dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .left_wheel_angle_i   (left_wheel_angle_i),
    .right_wheel_angle_i  (right_wheel_angle_i),
    .turned_i             (turned_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .x_position_o         (x_position_o),
    .y_position_o         (y_position_o),
    .heading_o            (heading_o),
    .distance_travelled_o (distance_travelled_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #1 clk_i = ~clk_i;

  // Bound the run
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("wheel_odometry_pose_update: mismatch");
    $finish;
  end

  // Score every accepted pose
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_pose.x_pos    = x_position_o;
      seen_pose.y_pos    = y_position_o;
      seen_pose.heading  = heading_o;
      seen_pose.distance = distance_travelled_o;
      tracker.check_pose(seen_pose);
    end
  end

  // Stall the pose channel: random modes of random length, plus long holds on demand
  initial begin : stall_pattern
    stall_mode_e mode;
    int          mode_left;
    out_stall_i = 1'b0;
    mode        = STALL_NONE;
    mode_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_wanted) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        hold_wanted = 1'b0;
        long_holds++;
        out_stall_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 200);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_COIN:  out_stall_i <= ($urandom_range(0, 1) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 8);
          default:     out_stall_i <= ((cycle_count % 7) < 3);
        endcase
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_req(input logic signed [31:0] left, input logic signed [31:0] right,
                          input logic turn);
    @(negedge clk_i);
    in_valid_i          <= 1'b1;
    left_wheel_angle_i  <= left;
    right_wheel_angle_i <= right;
    turned_i            <= turn;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_request(left, right, turn);
  endtask

  // Drop valid for a number of cycles
  task automatic pause_sender(input int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Wait until every expected pose has come back
  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write a register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== tracker.reg_value(idx))
      tracker.flag("register readback", tracker.reg_value(idx), readback);
  endtask

  task automatic apply_config(input logic [31:0] angle, input logic [31:0] radius,
                              input logic [31:0] period, input logic [31:0] factor);
    write_reg(wop_pkg::REG_TURN_ANGLE, angle);
    write_reg(wop_pkg::REG_WHEEL_RADIUS, radius);
    write_reg(wop_pkg::REG_CORR_PERIOD, period);
    write_reg(wop_pkg::REG_CORR_FACTOR, factor);
    settings++;
  endtask

  // Random requests in bursts: mostly smooth encoder walks, full-range jumps only where
  // the radius is small enough to keep the total path below saturation
  task automatic run_phase(input int count, input bit jumps, input bit pressure);
    int                 sent;
    int                 burst;
    int                 gap;
    int                 delta;
    logic signed [31:0] left;
    logic signed [31:0] right;
    sent = 0;
    if (pressure) hold_wanted = 1'b1;
    while (sent < count) begin
      burst = (pressure && sent == 0) ? 40 : $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < count; k++) begin
        if (jumps && $urandom_range(0, 4) == 0) begin
          left  = $urandom;
          right = $urandom;
        end else begin
          delta      = (int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP)
                       >>> $urandom_range(0, 16);
          walk_left  = walk_left + delta;
          delta      = (int'($urandom_range(0, 2 * WALK_STEP)) - WALK_STEP)
                       >>> $urandom_range(0, 16);
          walk_right = walk_right + delta;
          if (walk_left > WALK_SPAN || walk_left < -WALK_SPAN) walk_left = '0;
          if (walk_right > WALK_SPAN || walk_right < -WALK_SPAN) walk_right = '0;
          left  = walk_left;
          right = walk_right;
        end
        send_req(left, right, $urandom_range(0, 9) < 3);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) pause_sender(gap);
    end
    pause_sender(1);
    settle();
  endtask

  initial begin : stimulus
    logic [31:0] radius;
    tracker             = new();
    rst_ni              = 1'b0;
    in_valid_i          = 1'b0;
    left_wheel_angle_i  = '0;
    right_wheel_angle_i = '0;
    turned_i            = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    hold_wanted         = 1'b0;
    long_holds          = 0;
    settings            = 0;
    walk_left           = '0;
    walk_right          = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults: angle extremes, opposite wheels, turns up to the default period
    send_req(32'sd0, 32'sd0, 1'b0);
    send_req(ANG_MAX, ANG_MAX, 1'b1);
    send_req(ANG_MIN, ANG_MIN, 1'b1);
    send_req(ANG_MAX, ANG_MIN, 1'b0);
    send_req(-32'sd1, 32'sd1, 1'b1);
    send_req(ANG_MIN, ANG_MAX, 1'b1);
    send_req(32'sd0, 32'sd0, 1'b1);
    pause_sender(1);
    settle();

    // Period zero corrects on every eighth turn; factor zero clears the heading;
    // a turn angle beyond 2*pi still wraps
    apply_config(32'h7FFFF, wop_pkg::WHEEL_RADIUS_RST, 32'd0, 32'd0);
    for (int i = 1; i <= 9; i++) send_req(i * 4096, -i * 4096, 1'b1);
    pause_sender(1);
    settle();

    // Zero radius: the wheel distances are zero whatever the angles
    apply_config(32'd0, 32'd0, 32'd7, 32'd65535);
    send_req($urandom, $urandom, 1'b1);
    send_req($urandom, $urandom, 1'b0);
    send_req($urandom, $urandom, 1'b1);
    pause_sender(1);
    settle();

    // Random phases over several settings, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_config(32'd0, 32'd1, 32'd1, 32'd0);
        1: apply_config(32'd411774, 32'd65535, 32'd7, 32'd65535);
        2: apply_config(wop_pkg::TURN_ANGLE_RST, wop_pkg::WHEEL_RADIUS_RST,
                        wop_pkg::CORR_PERIOD_RST, wop_pkg::CORR_FACTOR_RST);
        default: begin
          radius = (ph % 2 == 1) ? $urandom_range(1, 256) : $urandom_range(1, 65535);
          apply_config($urandom_range(0, 411774), radius, $urandom_range(1, 7),
                       $urandom_range(0, 65535));
        end
      endcase
      run_phase(PHASE_ITEMS, tracker.wheel_radius <= 256, ph == 4);
    end

    // Full radius and full-range swings: drive the total path into saturation
    apply_config(wop_pkg::TURN_ANGLE_RST, 32'd65535, wop_pkg::CORR_PERIOD_RST,
                 wop_pkg::CORR_FACTOR_RST);
    send_req(ANG_MAX, ANG_MIN, 1'b1);
    send_req(ANG_MIN, ANG_MAX, 1'b0);
    send_req(ANG_MAX, ANG_MIN, 1'b1);
    send_req(ANG_MIN, ANG_MAX, 1'b0);
    send_req(32'sd0, 32'sd0, 1'b1);
    pause_sender(1);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests and checked %0d poses over %0d register settings.",
             tracker.requests, tracker.poses, settings);
    $display("Saw %0d turns, %0d heading corrections, %0d long output holds, saturation %0d.",
             tracker.turns, tracker.corrections, long_holds, tracker.saturated);
    if (tracker.mismatches == 0) begin
      $display("wheel_odometry_pose_update: match");
    end else begin
      $display("wheel_odometry_pose_update: mismatch");
    end
    $finish;
  end

endmodule
